/* hdl/tma_pkg.sv */
// Shared types and constants for the tap modifier assist block.
// No dependencies; the controller, datapath and top level import this package.
`default_nettype none
package tma_pkg;

    localparam int NKEYS     = 6;
    localparam int NGROUPS   = 3;
    localparam int CODE_W    = 16;
    localparam int KEY_W     = 3;
    localparam int CFG_IDX_W = 3;

    // Register indexes of the two timing windows; indexes below NKEYS are keycodes
    localparam logic [CFG_IDX_W-1:0] CFG_T1 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_T2 = 3'd7;

    // Input item kinds
    localparam logic OP_KEY   = 1'b0;
    localparam logic OP_HOUSE = 1'b1;

    typedef logic [CODE_W-1:0] code_t;

    localparam code_t CODE_RESET [NKEYS] = '{16'd226, 16'd230, 16'd224,
                                             16'd228, 16'd225, 16'd229};
    localparam code_t T1_RESET = 16'd120;
    localparam code_t T2_RESET = 16'd700;

    typedef enum logic [2:0] {
        PH_WAIT_PRESS    = 3'd0,
        PH_WAIT_REL_T1   = 3'd1,
        PH_CLEAN_NEXT    = 3'd2,
        PH_WAIT_PRESS_T2 = 3'd3,
        PH_WAIT_REL      = 3'd4,
        PH_CLEAN_ALL     = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_REG   = 2'd1,
        ACT_UNREG = 2'd2
    } act_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EVAL,
        CS_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic take_in;   // capture the input item
        logic eval;      // run the step and queue its actions
        logic emit;      // load the next result into the output register
    } ctl_cmd_t;

    typedef struct packed {
        logic pend_last; // the result on offer is the last of this item
        logic out_busy;  // output register full and not taken this cycle
    } ctl_sts_t;

    function automatic logic [1:0] group_of(input logic [KEY_W-1:0] key);
        return key[2:1];
    endfunction

endpackage
`default_nettype wire

/* hdl/tma_ifs.sv */
// Valid/ready channel interfaces for key items and action results.
// No dependencies.
`default_nettype none
interface tma_key_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] key_code;
    logic        key_pressed;
    logic [15:0] now_ms;

    modport source (output valid, op, key_code, key_pressed, now_ms, input ready);
    modport sink   (input valid, op, key_code, key_pressed, now_ms, output ready);
endinterface

interface tma_act_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [2:0] action_key;
    logic       assist_alt;
    logic       assist_ctrl;
    logic       assist_shift;
    logic [2:0] phase;
    logic       last_item;

    modport source (output valid, action, action_key, assist_alt, assist_ctrl,
                    assist_shift, phase, last_item, input ready);
    modport sink   (input valid, action, action_key, assist_alt, assist_ctrl,
                    assist_shift, phase, last_item, output ready);
endinterface
`default_nettype wire

/* hdl/tap_modifier_assist_fsm.sv */
// Top level of the tap modifier assist block: controller plus datapath.
// Depends on tma_pkg, tma_key_if, tma_act_if, tma_ctrl and tma_datapath.
//
// Usage:
//  - keys: one item per key event (op 0: key_code, key_pressed, now_ms) or
//    housekeeping pass (op 1: now_ms only). Valid/ready; accepted when both high.
//  - actions: one or more result items per input item, in key order 0..5.
//    Each carries the action (none/register/unregister), the key index, the
//    three group assist flags and the phase after the whole step; last_item
//    marks the final result of the input. An input with no action gives a
//    single "none" result.
//  - cfg_wen/cfg_idx/cfg_wdata: write keycodes (0..5) and the T1/T2 windows
//    (6, 7). Write only while idle.
//  - Timing: accept, evaluate, then one result per cycle from the output
//    register while the receiver takes them; the single output register
//    walks the action queue one key per cycle.
//  - keys.ready is high only while no item is in progress; the last result
//    may still wait in the output register while the next item is taken.
//  - Receiver stall: results hold in the output register and the walk pauses.
//  - Reset: phase 0, flags, held and sent bits cleared, registers take their
//    default keycodes and windows; no result pending.
//  - TIME_BITS sets the width of elapsed-time arithmetic (16..32).
`default_nettype none
module tap_modifier_assist_fsm
    import tma_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire code_t                cfg_wdata,
    tma_key_if.sink                   keys,
    tma_act_if.source                 actions
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;
    logic     in_ready;

    assign keys.ready = in_ready;

    tma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (keys.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tma_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata),
        .in_op      (keys.op),
        .in_code    (keys.key_code),
        .in_pressed (keys.key_pressed),
        .in_now     (keys.now_ms),
        .cmd        (cmd),
        .sts        (sts),
        .actions    (actions)
    );

endmodule
`default_nettype wire

/* hdl/tma_ctrl.sv */
// Controller FSM: capture, evaluate, then emit one result per cycle unless stalled.
// Depends on tma_pkg.
`default_nettype none
module tma_ctrl
    import tma_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output      logic     in_ready,
    input  wire ctl_sts_t sts,
    output      ctl_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CS_EVAL;
                end
            end
            CS_EVAL:
            begin
                state_next = CS_EMIT;
            end
            CS_EMIT:
            begin
                if (!sts.out_busy && sts.pend_last)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.take_in = in_valid;
            end
            CS_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            CS_EMIT:
            begin
                cmd.emit = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hdl/tma_datapath.sv */
// Datapath: config registers, assist state, action queue and output register.
// Depends on tma_pkg and tma_act_if.
`default_nettype none
module tma_datapath
    import tma_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire code_t                cfg_wdata,
    input  wire logic                 in_op,
    input  wire code_t                in_code,
    input  wire logic                 in_pressed,
    input  wire logic [15:0]          in_now,
    input  wire ctl_cmd_t             cmd,
    output      ctl_sts_t             sts,
    tma_act_if.source                 actions
);

    // configuration
    code_t code_reg [NKEYS];
    code_t t1_reg;
    code_t t2_reg;

    // captured item
    logic        op_reg;
    code_t       kc_reg;
    logic        pressed_reg;
    logic [15:0] now_reg;

    // assist state
    phase_t               phase_reg, phase_next;
    logic [KEY_W-1:0]     cur_reg, cur_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [NGROUPS-1:0]   grp_reg, grp_next;
    logic [NKEYS-1:0]     held_reg, held_next;
    logic [NKEYS-1:0]     em_reg, em_next;

    // action queue
    logic [NKEYS-1:0] pend_reg;
    act_t             kind_reg  [NKEYS];
    act_t             kind_next [NKEYS];

    // output register
    logic             out_valid_reg;
    act_t             out_act_reg;
    logic [KEY_W-1:0] out_key_reg;
    logic [NGROUPS-1:0] out_grp_reg;
    phase_t           out_phase_reg;
    logic             out_last_reg;

    logic [NKEYS-1:0]     match;
    logic [KEY_W-1:0]     hit_key;
    logic [KEY_W-1:0]     cur_idx;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic [KEY_W-1:0]     sel_key;
    logic [NKEYS-1:0]     rest;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NKEYS; i++)
            begin
                code_reg[i] <= CODE_RESET[i];
            end
            t1_reg <= T1_RESET;
            t2_reg <= T2_RESET;
        end
        else if (cfg_wen)
        begin
            for (int i = 0; i < NKEYS; i++)
            begin
                if (cfg_idx == CFG_IDX_W'(i))
                begin
                    code_reg[i] <= cfg_wdata;
                end
            end
            if (cfg_idx == CFG_T1)
            begin
                t1_reg <= cfg_wdata;
            end
            if (cfg_idx == CFG_T2)
            begin
                t2_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            op_reg      <= in_op;
            kc_reg      <= in_code;
            pressed_reg <= in_pressed;
            now_reg     <= in_now;
        end
    end

    always_comb
    begin
        hit_key = '0;
        for (int i = 0; i < NKEYS; i++)
        begin
            match[i] = (code_reg[i] == kc_reg);
            if (match[i])
            begin
                hit_key = KEY_W'(i);
            end
        end
    end

    // key index values 6 and 7 are unreachable; fold the key index anyway
    assign cur_idx = (cur_reg >= KEY_W'(NKEYS)) ? cur_reg - KEY_W'(NKEYS) : cur_reg;
    assign now_t   = TIME_BITS'(now_reg);
    assign elapsed = now_t - start_reg;

    // one step of the assist state machine, with per-key actions
    always_comb
    begin
        phase_next = phase_reg;
        cur_next   = cur_reg;
        start_next = start_reg;
        grp_next   = grp_reg;
        held_next  = held_reg;
        em_next    = em_reg;
        for (int i = 0; i < NKEYS; i++)
        begin
            kind_next[i] = ACT_NONE;
        end

        if (op_reg == OP_HOUSE)
        begin
            case (phase_reg)
                PH_WAIT_REL_T1:
                begin
                    if (elapsed >= TIME_BITS'(t1_reg))
                    begin
                        phase_next = PH_WAIT_REL;
                    end
                end
                PH_CLEAN_NEXT:
                begin
                    for (int i = 0; i < NKEYS; i++)
                    begin
                        if (em_next[i])
                        begin
                            kind_next[i] = ACT_UNREG;
                            em_next[i]   = 1'b0;
                        end
                    end
                    phase_next = PH_WAIT_PRESS_T2;
                end
                PH_WAIT_PRESS_T2, PH_CLEAN_ALL:
                begin
                    if (phase_reg == PH_CLEAN_ALL || elapsed >= TIME_BITS'(t2_reg))
                    begin
                        for (int i = 0; i < NKEYS; i++)
                        begin
                            if (em_next[i])
                            begin
                                kind_next[i] = ACT_UNREG;
                                em_next[i]   = 1'b0;
                            end
                        end
                        grp_next   = '0;
                        phase_next = PH_WAIT_PRESS;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (|match)
        begin
            for (int i = 0; i < NKEYS; i++)
            begin
                if (match[i])
                begin
                    held_next[i] = pressed_reg;
                end
            end
            case (phase_reg)
                PH_WAIT_PRESS:
                begin
                    if (pressed_reg)
                    begin
                        cur_next   = hit_key;
                        start_next = now_t;
                        phase_next = PH_WAIT_REL_T1;
                    end
                end
                PH_WAIT_REL_T1:
                begin
                    if (code_reg[cur_idx] != kc_reg)
                    begin
                        phase_next = PH_CLEAN_ALL;
                    end
                    else
                    begin
                        grp_next[group_of(hit_key)] = 1'b1;
                        start_next = now_t;
                        phase_next = PH_CLEAN_NEXT;
                    end
                end
                PH_WAIT_PRESS_T2:
                begin
                    if (!pressed_reg)
                    begin
                        phase_next = PH_CLEAN_ALL;
                    end
                    else
                    begin
                        // walk in key order; a matching key clears its group
                        // before a higher-numbered partner is looked at
                        for (int i = 0; i < NKEYS; i++)
                        begin
                            if (match[i])
                            begin
                                if (em_next[i])
                                begin
                                    kind_next[i] = ACT_UNREG;
                                    em_next[i]   = 1'b0;
                                end
                                grp_next[group_of(KEY_W'(i))] = 1'b0;
                            end
                            else if (grp_next[group_of(KEY_W'(i))] && !em_next[i])
                            begin
                                kind_next[i] = ACT_REG;
                                em_next[i]   = 1'b1;
                            end
                        end
                        cur_next   = hit_key;
                        start_next = now_t;
                        phase_next = PH_WAIT_REL_T1;
                    end
                end
                PH_WAIT_REL:
                begin
                    if (held_next == '0)
                    begin
                        phase_next = PH_CLEAN_ALL;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT_PRESS;
            cur_reg   <= '0;
            start_reg <= '0;
            grp_reg   <= '0;
            held_reg  <= '0;
            em_reg    <= '0;
            pend_reg  <= '0;
        end
        else if (cmd.eval)
        begin
            phase_reg <= phase_next;
            cur_reg   <= cur_next;
            start_reg <= start_next;
            grp_reg   <= grp_next;
            held_reg  <= held_next;
            em_reg    <= em_next;
            for (int i = 0; i < NKEYS; i++)
            begin
                pend_reg[i] <= (kind_next[i] != ACT_NONE);
            end
        end
        else if (cmd.emit)
        begin
            pend_reg <= rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            for (int i = 0; i < NKEYS; i++)
            begin
                kind_reg[i] <= kind_next[i];
            end
        end
    end

    // lowest pending key goes next; an empty queue gives one "none" result
    always_comb
    begin
        sel_key = '0;
        for (int i = NKEYS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                sel_key = KEY_W'(i);
            end
        end
        rest = pend_reg & ~(NKEYS'(1) << sel_key);
    end

    assign sts.pend_last = (rest == '0);
    assign sts.out_busy  = out_valid_reg && !actions.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (actions.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (pend_reg != '0)
            begin
                out_act_reg <= kind_reg[sel_key];
                out_key_reg <= sel_key;
            end
            else
            begin
                out_act_reg <= ACT_NONE;
                out_key_reg <= '0;
            end
            out_grp_reg   <= grp_reg;
            out_phase_reg <= phase_reg;
            out_last_reg  <= (rest == '0);
        end
    end

    assign actions.valid        = out_valid_reg;
    assign actions.action       = out_act_reg;
    assign actions.action_key   = out_key_reg;
    assign actions.assist_alt   = out_grp_reg[0];
    assign actions.assist_ctrl  = out_grp_reg[1];
    assign actions.assist_shift = out_grp_reg[2];
    assign actions.phase        = out_phase_reg;
    assign actions.last_item    = out_last_reg;

endmodule
`default_nettype wire
